// File: hw/rtl/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// Types and constants shared by the text console cursor writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

  typedef enum logic [1:0] {
    MODE_STREAM = 2'd0,
    MODE_PUT    = 2'd1,
    MODE_MOVE   = 2'd2,
    MODE_SET    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    SCR_TILE   = 2'd0,
    SCR_TEXT   = 2'd1,
    SCR_BITMAP = 2'd2,
    SCR_SPARE  = 2'd3
  } screen_t;

  typedef enum logic [1:0] {
    REG_SCREEN_MODE   = 2'd0,
    REG_NAME_BASE     = 2'd1,
    REG_PATTERN_BASE  = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_index_t;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;
  localparam logic [7:0] CH_FIRST   = 8'h20;
  localparam logic [7:0] CH_LAST    = 8'h7D;
  localparam logic [7:0] COORD_NEG  = 8'hFF;
  localparam logic [7:0] LAST_COL_TEXT = 8'd39;
  localparam logic [7:0] LAST_COL_TILE = 8'd31;
  localparam logic [2:0] BEAT_LAST  = 3'd7;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] char_code;
    logic [1:0] direction;
    logic [7:0] column;
    logic [7:0] row;
  } in_item_t;

  typedef struct packed {
    logic        write_valid;
    logic [13:0] vram_address;
    logic [7:0]  write_value;
    logic        use_font;
    logic [9:0]  font_address;
    logic [5:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic        last;
  } out_item_t;

  // One classified item between the front and the back.
  typedef struct packed {
    logic        write;
    logic        font;
    logic [13:0] addr;
    logic [7:0]  value;
    logic [6:0]  glyph;
    logic [5:0]  col;
    logic [4:0]  row;
  } q_entry_t;

endpackage

`default_nettype wire

// File: hw/rtl/tccw_if.sv
// ----------------------------------------------------------------------------
// tccw_if
// Handshake channels of the text console cursor writer.
// ----------------------------------------------------------------------------
`default_nettype none

interface tccw_in_if;
  logic               valid;
  logic               ready;
  tccw_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tccw_out_if;
  logic                valid;
  logic                ready;
  tccw_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tccw_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [13:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tccw_front.sv
// ----------------------------------------------------------------------------
// tccw_front
// Holds the registers and the cursor, classifies each event and computes
// its write address and the cursor position that follows it.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_front #(
  parameter int LAST_ROW = 23
) (
  input  logic               clk,
  input  logic               rst,
  tccw_cfg_if.sink           cfg,
  tccw_in_if.sink            item_in,
  output logic               q_push,
  output tccw_pkg::q_entry_t q_entry,
  input  logic               q_full
);
  import tccw_pkg::*;

  localparam int RowW = $clog2(LAST_ROW + 1);
  localparam logic [7:0] LastRow8 = 8'(LAST_ROW);

  logic [1:0]      screen_mode;
  logic [13:0]     name_base;
  logic [13:0]     pattern_base;
  logic [5:0]      cur_col;
  logic [RowW-1:0] cur_row;

  logic [7:0]  col8, row8, mx, ch;
  logic [7:0]  pc, pr, nc, nr;
  logic        printable, do_place, emit, bitmap;
  logic [13:0] offset;

  always_comb begin
    col8      = {2'b00, cur_col};
    row8      = 8'(cur_row);
    mx        = (screen_mode == SCR_TEXT) ? LAST_COL_TEXT : LAST_COL_TILE;
    bitmap    = (screen_mode == SCR_BITMAP);
    ch        = item_in.data.char_code;
    printable = (ch >= CH_FIRST) && (ch <= CH_LAST);
    do_place  = 1'b0;
    emit      = 1'b0;
    pc        = col8;
    pr        = row8;
    unique case (item_in.data.mode)
      MODE_STREAM: begin
        if (ch == CH_NEWLINE) begin
          do_place = 1'b1;
          pr       = row8 + 8'd1;
        end else if (ch == CH_RETURN) begin
          do_place = 1'b1;
          pc       = 8'd0;
        end else if (printable) begin
          emit     = 1'b1;
          do_place = 1'b1;
          pc       = col8 + 8'd1;
        end
      end
      MODE_PUT: begin
        emit = printable;
      end
      MODE_MOVE: begin
        do_place = 1'b1;
        unique case (item_in.data.direction)
          DIR_UP:    pr = row8 - 8'd1;
          DIR_DOWN:  pr = row8 + 8'd1;
          DIR_LEFT:  pc = col8 - 8'd1;
          DIR_RIGHT: pc = col8 + 8'd1;
          default:   pc = col8;
        endcase
      end
      MODE_SET: begin
        do_place = 1'b1;
        pc       = item_in.data.column;
        pr       = item_in.data.row;
      end
      default: do_place = 1'b0;
    endcase

    // Column wrap first, since it may move the row across its own limits.
    nc = pc;
    nr = pr;
    if (pc == COORD_NEG) begin
      nc = mx;
      nr = pr - 8'd1;
    end else if (pc > mx) begin
      nc = 8'd0;
      nr = pr + 8'd1;
    end
    if (nr == COORD_NEG) begin
      nr = LastRow8;
    end else if (nr > LastRow8) begin
      nr = 8'd0;
    end

    // The write address uses the cursor as it stands before the event.
    offset = (14'(row8) << 5) + ((screen_mode == SCR_TEXT) ? (14'(row8) << 3) : 14'd0)
           + 14'(col8);

    q_entry.write = emit;
    q_entry.font  = emit && bitmap;
    if (!emit) begin
      q_entry.addr = 14'd0;
    end else if (bitmap) begin
      q_entry.addr = pattern_base + (offset << 3);
    end else begin
      q_entry.addr = name_base + offset;
    end
    q_entry.value = (emit && !bitmap) ? ch : 8'd0;
    q_entry.glyph = (emit && bitmap) ? 7'(ch - CH_FIRST) : 7'd0;
    q_entry.col   = do_place ? nc[5:0] : cur_col;
    q_entry.row   = do_place ? nr[4:0] : row8[4:0];
  end

  assign item_in.ready = !q_full;
  assign q_push        = item_in.valid && !q_full;
  assign cfg.ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_mode  <= 2'd0;
      name_base    <= 14'd0;
      pattern_base <= 14'd0;
      cur_col      <= 6'd0;
      cur_row      <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_SCREEN_MODE:  screen_mode  <= cfg.data[1:0];
          REG_NAME_BASE:    name_base    <= cfg.data;
          REG_PATTERN_BASE: pattern_base <= cfg.data;
          default:          screen_mode  <= screen_mode;
        endcase
      end
      if (q_push && do_place) begin
        cur_col <= nc[5:0];
        cur_row <= RowW'(nr);
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tccw_queue.sv
// ----------------------------------------------------------------------------
// tccw_queue
// Short FIFO of classified events between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tccw_pkg::q_entry_t push_entry,
  input  logic               pop,
  output tccw_pkg::q_entry_t head,
  output logic               empty,
  output logic               full
);
  import tccw_pkg::*;

  q_entry_t         slots [QDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;
  logic [QPtrW:0]   count;

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == (QPtrW + 1)'(QDepth));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tccw_back.sv
// ----------------------------------------------------------------------------
// tccw_back
// Expands each classified event into its result beats: one for a name
// table write or a cursor-only event, eight for a bitmap glyph.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_back (
  input  logic               clk,
  input  logic               rst,
  input  tccw_pkg::q_entry_t head,
  input  logic               q_empty,
  output logic               q_pop,
  tccw_out_if.source         result_out
);
  import tccw_pkg::*;

  logic      out_valid;
  out_item_t out_data;
  logic      active;
  logic [2:0] beat;
  q_entry_t  cur;

  q_entry_t   src;
  logic [2:0] beat_sel;
  logic       load_ok, fire, is_final;
  out_item_t  beat_data;

  always_comb begin
    load_ok  = !out_valid || result_out.ready;
    src      = active ? cur : head;
    beat_sel = active ? beat : 3'd0;
    fire     = load_ok && (active || !q_empty);
    is_final = !src.font || (beat_sel == BEAT_LAST);

    beat_data.write_valid   = src.write;
    beat_data.vram_address  = src.addr + 14'(beat_sel);
    beat_data.write_value   = src.value;
    beat_data.use_font      = src.font;
    beat_data.font_address  = src.font ? {src.glyph, beat_sel} : 10'd0;
    beat_data.cursor_column = src.col;
    beat_data.cursor_row    = src.row;
    beat_data.last          = is_final;
  end

  // The head leaves the queue on its first beat; later beats run from cur.
  assign q_pop             = fire && !active;
  assign result_out.valid  = out_valid;
  assign result_out.data   = out_data;

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= beat_data;
      cur      <= src;
      beat     <= beat_sel + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      active    <= 1'b0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
        active    <= !is_final;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/text_console_cursor_writer.sv
// An accepted event is written into the queue, and the back end registers
// its result beats. Throughput: one event per cycle for cursor moves and
// name table writes; a bitmap glyph gives eight beats, one beat per cycle
// from the back end's beat counter, while the result port is ready. A
// four-entry queue lets events enter while a glyph drains. Reset puts the
// cursor at column 0, row 0, clears all registers and empties the queue.
// ----------------------------------------------------------------------------
// text_console_cursor_writer
// Turns console events into video memory writes while tracking the cursor.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_writer #(
  parameter int LAST_ROW = 23
) (
  input logic        clk,
  input logic        rst,
  tccw_cfg_if.sink   cfg,
  tccw_in_if.sink    item_in,
  tccw_out_if.source result_out
);
  import tccw_pkg::*;

  logic     q_push, q_pop, q_empty, q_full;
  q_entry_t q_entry, q_head;

  tccw_front #(
    .LAST_ROW (LAST_ROW)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .item_in (item_in),
    .q_push  (q_push),
    .q_entry (q_entry),
    .q_full  (q_full)
  );

  tccw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty),
    .full       (q_full)
  );

  tccw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .result_out (result_out)
  );

endmodule

`default_nettype wire

// File: dv/tb_text_console_cursor_writer.sv
// ----------------------------------------------------------------------------
// tb_text_console_cursor_writer
// Self-checking bench for the text console cursor writer. Console events go
// in through the event channel, and a cursor and video memory model predicts
// every result beat. Register settings change between phases while the block
// is idle, and both channels stall at random.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_writer;
  timeunit 1ns;
  timeprecision 1ps;

  import tccw_pkg::*;

  localparam int LAST_ROW     = 23;
  localparam int DRAIN_CYCLES = 6;
  localparam int TIMEOUT_NS   = 20_000_000;

  logic clk = 1'b0;
  logic rst;

  tccw_cfg_if cfg_ch();
  tccw_in_if  in_ch();
  tccw_out_if out_ch();

  text_console_cursor_writer #(.LAST_ROW(LAST_ROW)) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_ch),
    .item_in    (in_ch),
    .result_out (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  // Shadow copy of the registers and the cursor.
  screen_t     scr_mode;
  logic [13:0] nt_base;
  logic [13:0] pt_base;
  logic [7:0]  csr_col;
  logic [7:0]  csr_row;

  out_item_t pending_beats[$];
  out_item_t want;
  out_item_t got;
  int        bad_beats;

  bit tx_throttle;
  bit rx_throttle;
  int rx_hold_cycles;
  int rx_wait;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] last_column();
    return (scr_mode == SCR_TEXT) ? LAST_COL_TEXT : LAST_COL_TILE;
  endfunction

  function automatic void move_cursor(logic [7:0] c, logic [7:0] r);
    logic [7:0] mx;
    mx = last_column();
    if (c == COORD_NEG) begin
      c = mx;
      r = r - 8'd1;
    end else if (c > mx) begin
      c = 8'd0;
      r = r + 8'd1;
    end
    if (r == COORD_NEG) begin
      r = 8'(LAST_ROW);
    end else if (r > 8'(LAST_ROW)) begin
      r = 8'd0;
    end
    csr_col = c;
    csr_row = r;
  endfunction

  // Works out the beats that one console event causes and queues them.
  function automatic void predict_console_event(in_item_t ev);
    out_item_t   beats[$];
    out_item_t   b;
    logic        emits;
    int unsigned offset;
    int unsigned glyph_base;
    emits = (ev.mode == MODE_STREAM || ev.mode == MODE_PUT) &&
            ev.char_code >= CH_FIRST && ev.char_code <= CH_LAST;
    if (emits) begin
      // The address uses the stored column even when it lies past the width.
      offset = csr_row * (last_column() + 8'd1) + csr_col;
      glyph_base = ev.char_code;
      glyph_base = (glyph_base - 32) * 8;
      if (scr_mode == SCR_BITMAP) begin
        for (int i = 0; i < 8; i++) begin
          b = '0;
          b.write_valid  = 1'b1;
          b.vram_address = 14'(pt_base + (offset << 3) + i);
          b.use_font     = 1'b1;
          b.font_address = 10'(glyph_base + i);
          beats.push_back(b);
        end
      end else begin
        b = '0;
        b.write_valid  = 1'b1;
        b.vram_address = 14'(nt_base + offset);
        b.write_value  = ev.char_code;
        beats.push_back(b);
      end
    end
    case (mode_t'(ev.mode))
      MODE_STREAM: begin
        if (ev.char_code == CH_NEWLINE) begin
          move_cursor(csr_col, csr_row + 8'd1);
        end else if (ev.char_code == CH_RETURN) begin
          move_cursor(8'd0, csr_row);
        end else if (emits) begin
          move_cursor(csr_col + 8'd1, csr_row);
        end
      end
      MODE_MOVE: begin
        case (dir_t'(ev.direction))
          DIR_UP:    move_cursor(csr_col, csr_row - 8'd1);
          DIR_DOWN:  move_cursor(csr_col, csr_row + 8'd1);
          DIR_LEFT:  move_cursor(csr_col - 8'd1, csr_row);
          default:   move_cursor(csr_col + 8'd1, csr_row);
        endcase
      end
      MODE_SET: move_cursor(ev.column, ev.row);
      default: ;
    endcase
    if (beats.size() == 0) begin
      b = '0;
      beats.push_back(b);
    end
    foreach (beats[k]) begin
      beats[k].cursor_column = csr_col[5:0];
      beats[k].cursor_row    = csr_row[4:0];
      beats[k].last          = (k == beats.size() - 1);
      pending_beats.push_back(beats[k]);
    end
  endfunction

  task automatic write_reg(reg_index_t idx, logic [13:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_SCREEN_MODE:  scr_mode = screen_t'(value[1:0]);
      REG_NAME_BASE:    nt_base = value;
      REG_PATTERN_BASE: pt_base = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_event(in_item_t ev);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.data  <= ev;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_console_event(ev);
    gap = tx_throttle ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering events and waits until every predicted beat has arrived.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t noise_event();
    in_item_t ev;
    ev.mode      = 2'($urandom);
    ev.char_code = 8'($urandom);
    ev.direction = 2'($urandom);
    ev.column    = 8'($urandom);
    ev.row       = 8'($urandom);
    return ev;
  endfunction

  task automatic put_byte(mode_t m, logic [7:0] ch);
    in_item_t ev;
    ev = noise_event();
    ev.mode = m;
    ev.char_code = ch;
    send_event(ev);
  endtask

  task automatic step_cursor(dir_t d);
    in_item_t ev;
    ev = noise_event();
    ev.mode = MODE_MOVE;
    ev.direction = d;
    send_event(ev);
  endtask

  task automatic place_at(logic [7:0] c, logic [7:0] r);
    in_item_t ev;
    ev = noise_event();
    ev.mode = MODE_SET;
    ev.column = c;
    ev.row = r;
    send_event(ev);
  endtask

  function automatic in_item_t random_event();
    in_item_t ev;
    int       pick;
    ev = noise_event();
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      ev.mode = MODE_STREAM;
      ev.char_code = 8'($urandom_range(CH_FIRST, CH_LAST));
    end else if (pick < 47) begin
      ev.mode = MODE_STREAM;
      ev.char_code = CH_NEWLINE;
    end else if (pick < 51) begin
      ev.mode = MODE_STREAM;
      ev.char_code = CH_RETURN;
    end else if (pick < 55) begin
      ev.mode = MODE_STREAM;
    end else if (pick < 70) begin
      ev.mode = MODE_PUT;
      if ($urandom_range(0, 3) != 0) ev.char_code = 8'($urandom_range(CH_FIRST, CH_LAST));
    end else if (pick < 85) begin
      ev.mode = MODE_MOVE;
    end else begin
      ev.mode = MODE_SET;
      pick = $urandom_range(0, 3);
      if (pick == 0) ev.column = COORD_NEG;
      else if (pick > 1) ev.column = 8'($urandom_range(0, 39));
      pick = $urandom_range(0, 3);
      if (pick == 0) ev.row = COORD_NEG;
      else if (pick > 1) ev.row = 8'($urandom_range(0, LAST_ROW));
    end
    return ev;
  endfunction

  function automatic logic [13:0] pick_base();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 14'h0000;
    if (r == 1) return 14'h3FFF;
    return 14'($urandom);
  endfunction

  // Receiver side: a long hold-off when asked for, otherwise random stalls while rx_throttle is set.
  always @(posedge clk) begin
    if (rx_hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      rx_hold_cycles--;
    end else if (rx_wait > 0) begin
      out_ch.ready <= 1'b0;
      rx_wait--;
    end else if (rx_throttle && $urandom_range(0, 3) == 0) begin
      out_ch.ready <= 1'b0;
      rx_wait = pick_gap();
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Every accepted beat is compared with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = out_ch.data;
      if (pending_beats.size() == 0) begin
        bad_beats++;
        if (bad_beats <= 10) begin
          $display("unexpected beat: wv=%0b addr=%h val=%h font=%0b fa=%h col=%0d row=%0d last=%0b",
                   got.write_valid, got.vram_address, got.write_value, got.use_font,
                   got.font_address, got.cursor_column, got.cursor_row, got.last);
        end
      end else begin
        want = pending_beats.pop_front();
        if (got.write_valid !== want.write_valid || got.vram_address !== want.vram_address ||
            got.write_value !== want.write_value || got.use_font !== want.use_font ||
            got.font_address !== want.font_address ||
            got.cursor_column !== want.cursor_column ||
            got.cursor_row !== want.cursor_row || got.last !== want.last) begin
          bad_beats++;
          if (bad_beats <= 10) begin
            $display("mismatch at %0t: expected wv=%0b addr=%h val=%h font=%0b fa=%h col=%0d row=%0d last=%0b",
                     $realtime, want.write_valid, want.vram_address, want.write_value,
                     want.use_font, want.font_address, want.cursor_column, want.cursor_row,
                     want.last);
            $display("  actual wv=%0b addr=%h val=%h font=%0b fa=%h col=%0d row=%0d last=%0b",
                     got.write_valid, got.vram_address, got.write_value, got.use_font,
                     got.font_address, got.cursor_column, got.cursor_row, got.last);
          end
        end
      end
    end
  end

  // Tile mode with a name table at the top of memory, so addresses wrap.
  task automatic test_stream_bytes();
    write_reg(REG_UNUSED, 14'h2AAA);
    write_reg(REG_NAME_BASE, 14'h3FFF);
    write_reg(REG_PATTERN_BASE, 14'h0000);
    put_byte(MODE_STREAM, CH_FIRST);
    put_byte(MODE_STREAM, CH_LAST);
    put_byte(MODE_STREAM, 8'h41);
    put_byte(MODE_STREAM, 8'h1F);
    put_byte(MODE_STREAM, 8'h7E);
    put_byte(MODE_STREAM, 8'h00);
    put_byte(MODE_STREAM, 8'hFF);
    put_byte(MODE_STREAM, CH_NEWLINE);
    put_byte(MODE_STREAM, CH_RETURN);
  endtask

  task automatic test_put_and_move();
    put_byte(MODE_PUT, CH_LAST);
    put_byte(MODE_PUT, CH_NEWLINE);
    step_cursor(DIR_UP);
    step_cursor(DIR_UP);
    step_cursor(DIR_DOWN);
    step_cursor(DIR_LEFT);
    step_cursor(DIR_RIGHT);
  endtask

  task automatic test_set_cursor();
    place_at(COORD_NEG, COORD_NEG);
    place_at(8'd200, 8'd30);
    place_at(8'd31, 8'(LAST_ROW));
    put_byte(MODE_STREAM, 8'h41);
    place_at(8'd0, COORD_NEG);
    place_at(8'd32, 8'(LAST_ROW));
  endtask

  // A column left past the edge by the text mode must carry into the next row.
  task automatic test_screen_modes();
    drain();
    write_reg(REG_SCREEN_MODE, 14'(SCR_TEXT));
    tx_throttle = 1'b1;
    rx_throttle = 1'b1;
    place_at(8'd39, 8'd10);
    put_byte(MODE_STREAM, 8'h42);
    place_at(8'd39, 8'd5);
    drain();
    write_reg(REG_PATTERN_BASE, 14'h3FFF);
    write_reg(REG_SCREEN_MODE, 14'(SCR_BITMAP));
    put_byte(MODE_STREAM, CH_LAST);
    drain();
    write_reg(REG_SCREEN_MODE, 14'(SCR_SPARE));
    put_byte(MODE_STREAM, CH_FIRST);
  endtask

  // The receiver holds off while glyphs keep coming, so the queue fills up.
  task automatic test_backpressure();
    drain();
    write_reg(REG_SCREEN_MODE, 14'(SCR_BITMAP));
    tx_throttle = 1'b0;
    rx_throttle = 1'b0;
    rx_hold_cycles = 120;
    repeat (24) put_byte(MODE_STREAM, 8'($urandom_range(CH_FIRST, CH_LAST)));
  endtask

  task automatic test_random_traffic(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      drain();
      write_reg(REG_NAME_BASE, pick_base());
      write_reg(REG_PATTERN_BASE, pick_base());
      write_reg(REG_SCREEN_MODE, {12'($urandom), 2'($urandom)});
      tx_throttle = (p % 3) != 0;
      rx_throttle = (p % 4) != 1;
      for (int n = 0; n < per_phase; n++) begin
        send_event(random_event());
        if ($urandom_range(0, 39) == 0) drain();
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    scr_mode = SCR_TILE;
    nt_base = '0;
    pt_base = '0;
    csr_col = '0;
    csr_row = '0;
    bad_beats = 0;
    tx_throttle = 1'b0;
    rx_throttle = 1'b0;
    rx_hold_cycles = 0;
    rx_wait = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_stream_bytes();
    test_put_and_move();
    test_set_cursor();
    test_screen_modes();
    test_backpressure();
    test_random_traffic(8, 48);

    drain();
    repeat (20) @(posedge clk);
    if (bad_beats == 0 && pending_beats.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/tccw_pkg.sv
hw/rtl/tccw_if.sv
hw/rtl/tccw_front.sv
hw/rtl/tccw_queue.sv
hw/rtl/tccw_back.sv
hw/rtl/text_console_cursor_writer.sv
dv/tb_text_console_cursor_writer.sv
